### design/mmi_pkg.sv
// Shared types and constants for the median of maximum interest block.
package mmi_pkg;

  // Register indexes on the configuration port.
  localparam logic REG_FCST_COUNT = 1'b0;
  localparam logic REG_OBS_COUNT  = 1'b1;

  // Width of the object count registers.
  localparam int COUNT_W = 9;

  // Number of order statistics tracked during the scan: a low and a high
  // middle element for the forecast, observation and combined lists.
  localparam int NUM_TARGETS = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_PASS,
    ST_RESULT,
    ST_CLEAR
  } mmi_state_t;

  typedef struct packed {
    logic rec_read;
    logic rec_write;
    logic scan_init;
    logic scan_step;
    logic pass_end;
    logic result_load;
    logic clr_step;
  } mmi_cmd_t;

  typedef struct packed {
    logic rec_last;
    logic both_empty;
    logic idx_done;
    logic bit_done;
    logic clr_done;
    logic out_full;
  } mmi_stat_t;

endpackage

### design/mmi_ram.sv
// Generic simple dual-port RAM with a registered read port.
module mmi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/mmi_ctrl.sv
// Controller state machine for the median of maximum interest block.
module mmi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  mmi_pkg::mmi_stat_t stat,
  output mmi_pkg::mmi_cmd_t  cmd,
  output logic              in_stall
);
  import mmi_pkg::*;

  mmi_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.rec_read = 1'b1;
          state_next   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.rec_write = 1'b1;
        cmd.scan_init = 1'b1;
        if (stat.rec_last) begin
          state_next = stat.both_empty ? ST_RESULT : ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.idx_done) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_PASS;
      end
      ST_PASS: begin
        cmd.pass_end = 1'b1;
        state_next   = stat.bit_done ? ST_RESULT : ST_SCAN;
      end
      ST_RESULT: begin
        if (!stat.out_full) begin
          cmd.result_load = 1'b1;
          state_next      = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/mmi_dp.sv
// Datapath: maxima stores, bitwise order statistic search and result register.
module mmi_dp #(
  parameter int MAX_OBJECTS        = 256,
  parameter int INTEREST_FRAC_BITS = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mmi_pkg::mmi_cmd_t     cmd,
  output mmi_pkg::mmi_stat_t    stat,
  input  logic [mmi_pkg::COUNT_W-1:0] fcst_count,
  input  logic [mmi_pkg::COUNT_W-1:0] obs_count,
  input  logic                  is_simple_pair,
  input  logic [(MAX_OBJECTS > 1 ? $clog2(MAX_OBJECTS) : 1)-1:0] fcst_object,
  input  logic [(MAX_OBJECTS > 1 ? $clog2(MAX_OBJECTS) : 1)-1:0] obs_object,
  input  logic [INTEREST_FRAC_BITS:0] interest_value,
  input  logic                  last_record,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic signed [INTEREST_FRAC_BITS+1:0] fcst_median,
  output logic signed [INTEREST_FRAC_BITS+1:0] obs_median,
  output logic signed [INTEREST_FRAC_BITS+1:0] combined_median
);
  import mmi_pkg::*;

  localparam int VW  = INTEREST_FRAC_BITS + 1;
  localparam int OW  = INTEREST_FRAC_BITS + 2;
  localparam int IW  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int NW  = ($clog2(MAX_OBJECTS + 1) > COUNT_W) ? $clog2(MAX_OBJECTS + 1) : COUNT_W;
  localparam int CW  = NW + 1;
  localparam int BW  = $clog2(VW);
  localparam logic [VW-1:0] ONE     = VW'(1) << INTEREST_FRAC_BITS;
  localparam logic [OW-1:0] NEG_ONE = {2'b11, {INTEREST_FRAC_BITS{1'b0}}};

  // Clamped counts.
  logic [NW-1:0] nf, no, m;
  logic [CW-1:0] nc;
  assign nf = (NW'(fcst_count) > NW'(MAX_OBJECTS)) ? NW'(MAX_OBJECTS) : NW'(fcst_count);
  assign no = (NW'(obs_count) > NW'(MAX_OBJECTS)) ? NW'(MAX_OBJECTS) : NW'(obs_count);
  assign m  = (nf > no) ? nf : no;
  assign nc = CW'(nf) + CW'(no);

  // Record registers.
  logic [IW-1:0] fo_r, oo_r;
  logic [VW-1:0] iv_r;
  logic          hit_r, last_r;

  always_ff @(posedge clk) begin
    if (cmd.rec_read) begin
      fo_r   <= fcst_object;
      oo_r   <= obs_object;
      iv_r   <= (interest_value > ONE) ? ONE : interest_value;
      hit_r  <= is_simple_pair && (NW'(fcst_object) < nf) && (NW'(obs_object) < no);
      last_r <= last_record;
    end
  end

  // Index and bit counters.
  logic [IW-1:0] idx;
  logic [BW-1:0] bit_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.scan_init || cmd.pass_end || cmd.result_load) begin
      idx <= '0;
    end else if (cmd.scan_step || cmd.clr_step) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      bit_pos <= BW'(VW - 1);
    end else if (cmd.pass_end) begin
      bit_pos <= bit_pos - BW'(1);
    end
  end

  // Stores.
  logic [VW-1:0] f_rdata, o_rdata, f_wdata, o_wdata;
  logic [IW-1:0] raddr_f, raddr_o, waddr_f, waddr_o;
  logic          we;

  assign raddr_f = cmd.rec_read ? fcst_object : idx;
  assign raddr_o = cmd.rec_read ? obs_object : idx;
  assign waddr_f = cmd.rec_write ? fo_r : idx;
  assign waddr_o = cmd.rec_write ? oo_r : idx;
  assign we      = (cmd.rec_write && hit_r) || cmd.clr_step;
  assign f_wdata = cmd.rec_write ? ((iv_r > f_rdata) ? iv_r : f_rdata) : '0;
  assign o_wdata = cmd.rec_write ? ((iv_r > o_rdata) ? iv_r : o_rdata) : '0;

  mmi_ram #(.WIDTH(VW), .DEPTH(MAX_OBJECTS)) u_fcst_ram (
    .clk(clk), .we(we), .waddr(waddr_f), .wdata(f_wdata), .raddr(raddr_f), .rdata(f_rdata)
  );

  mmi_ram #(.WIDTH(VW), .DEPTH(MAX_OBJECTS)) u_obs_ram (
    .clk(clk), .we(we), .waddr(waddr_o), .wdata(o_wdata), .raddr(raddr_o), .rdata(o_rdata)
  );

  // Scan read tracking.
  logic          rd_vld;
  logic [IW-1:0] rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_step;
    end
    rd_idx <= idx;
  end

  // Order statistic search: targets 0/1 forecast, 2/3 observation, 4/5 combined.
  logic [VW-1:0] pre  [NUM_TARGETS];
  logic [VW-1:0] trial[NUM_TARGETS];
  logic [CW-1:0] cnt  [NUM_TARGETS];
  logic [CW-1:0] rank [NUM_TARGETS];
  logic [1:0]    inc  [NUM_TARGETS];
  logic          f_in, o_in;

  assign f_in = rd_vld && (NW'(rd_idx) < nf);
  assign o_in = rd_vld && (NW'(rd_idx) < no);

  assign rank[0] = (CW'(nf) - CW'(1)) >> 1;
  assign rank[1] = CW'(nf) >> 1;
  assign rank[2] = (CW'(no) - CW'(1)) >> 1;
  assign rank[3] = CW'(no) >> 1;
  assign rank[4] = (nc - CW'(1)) >> 1;
  assign rank[5] = nc >> 1;

  always_comb begin
    for (int j = 0; j < NUM_TARGETS; j++) begin
      trial[j] = pre[j] | (VW'(1) << bit_pos);
      if (j < 2) begin
        inc[j] = {1'b0, f_in && (f_rdata < trial[j])};
      end else if (j < 4) begin
        inc[j] = {1'b0, o_in && (o_rdata < trial[j])};
      end else begin
        inc[j] = 2'({1'b0, f_in && (f_rdata < trial[j])})
               + 2'({1'b0, o_in && (o_rdata < trial[j])});
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_TARGETS; j++) begin
      if (cmd.scan_init) begin
        pre[j] <= '0;
        cnt[j] <= '0;
      end else if (cmd.pass_end) begin
        if (cnt[j] <= rank[j]) begin
          pre[j] <= trial[j];
        end
        cnt[j] <= '0;
      end else if (rd_vld) begin
        cnt[j] <= cnt[j] + CW'(inc[j]);
      end
    end
  end

  // Medians from the low and high middle elements.
  logic [VW:0]   f_sum, o_sum, c_sum;
  logic [OW-1:0] f_med, o_med, c_med;

  assign f_sum = ({1'b0, pre[0]} + {1'b0, pre[1]}) >> 1;
  assign o_sum = ({1'b0, pre[2]} + {1'b0, pre[3]}) >> 1;
  assign c_sum = ({1'b0, pre[4]} + {1'b0, pre[5]}) >> 1;

  always_comb begin
    if (nc == '0) begin
      f_med = '0;
      o_med = '0;
      c_med = '0;
    end else begin
      f_med = (nf == '0) ? NEG_ONE : OW'(f_sum);
      o_med = (no == '0) ? NEG_ONE : OW'(o_sum);
      c_med = OW'(c_sum);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      fcst_median     <= f_med;
      obs_median      <= o_med;
      combined_median <= c_med;
    end
  end

  assign stat.rec_last   = last_r;
  assign stat.both_empty = (nc == '0);
  assign stat.idx_done   = (NW'(idx) == m - NW'(1));
  assign stat.bit_done   = (bit_pos == '0);
  assign stat.clr_done   = (idx == IW'(MAX_OBJECTS - 1));
  assign stat.out_full   = out_valid;

endmodule

### design/median_of_max_interest.sv
// Top level of the median of maximum interest block: configuration port and submodules.
//
// This block reads a set of pair records and keeps, for every forecast and every
// observation object, the largest interest seen (saturated to 1.0). Records that
// are not simple pairs, or whose object numbers are at or above the configured
// counts, are skipped. Each record is read from both maxima stores and then
// written back. On the record flagged last the block searches the stores for the
// middle elements one value bit per pass, from the most significant bit down.
// Each pass reads one entry of each store per cycle and ends with a drain state
// for the read latency and a pass state for the bit decision; with both counts
// zero the scan is skipped. The result then waits in an output register while
// the stores are cleared by a pass over all MAX_OBJECTS entries, one entry per
// cycle; the same clearing pass runs after reset, and no item is accepted during
// it. An empty group yields -1.0, and when both groups are empty all three
// medians are zero. Counts above MAX_OBJECTS act as MAX_OBJECTS. Counts must be
// written only while idle.
module median_of_max_interest #(
  parameter int MAX_OBJECTS        = 256,
  parameter int INTEREST_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        is_simple_pair,
  input  logic [(MAX_OBJECTS > 1 ? $clog2(MAX_OBJECTS) : 1)-1:0] fcst_object,
  input  logic [(MAX_OBJECTS > 1 ? $clog2(MAX_OBJECTS) : 1)-1:0] obs_object,
  input  logic [INTEREST_FRAC_BITS:0] interest_value,
  input  logic        last_record,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [INTEREST_FRAC_BITS+1:0] fcst_median,
  output logic signed [INTEREST_FRAC_BITS+1:0] obs_median,
  output logic signed [INTEREST_FRAC_BITS+1:0] combined_median
);
  import mmi_pkg::*;

  // The count registers sit at byte addresses 0 and 4; bit 2 picks one.
  logic [COUNT_W-1:0] fcst_count, obs_count;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcst_count <= '0;
      obs_count  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FCST_COUNT: fcst_count <= pwdata[COUNT_W-1:0];
        REG_OBS_COUNT:  obs_count  <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FCST_COUNT: prdata = 32'(fcst_count);
      REG_OBS_COUNT:  prdata = 32'(obs_count);
      default:        prdata = '0;
    endcase
  end

  // The controller sequences record loads, the search passes, the result
  // hand-off and the clearing pass; the datapath does the work.
  mmi_cmd_t  cmd;
  mmi_stat_t stat;

  mmi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .stat(stat), .cmd(cmd), .in_stall(in_stall)
  );

  mmi_dp #(
    .MAX_OBJECTS(MAX_OBJECTS),
    .INTEREST_FRAC_BITS(INTEREST_FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .fcst_count(fcst_count), .obs_count(obs_count),
    .is_simple_pair(is_simple_pair), .fcst_object(fcst_object), .obs_object(obs_object),
    .interest_value(interest_value), .last_record(last_record),
    .out_stall(out_stall), .out_valid(out_valid),
    .fcst_median(fcst_median), .obs_median(obs_median), .combined_median(combined_median)
  );

  // A new result is never loaded over one that has not been taken.
  assert property (@(posedge clk) disable iff (rst) cmd.result_load |-> !out_valid)
    else $error("result loaded while previous result pending");

  // Every accepted item is written back in the following cycle.
  assert property (@(posedge clk) disable iff (rst) cmd.rec_read |=> cmd.rec_write)
    else $error("accepted item was not written back");

  // A loaded result is presented on the next cycle.
  assert property (@(posedge clk) disable iff (rst) cmd.result_load |=> out_valid)
    else $error("loaded result not presented");

endmodule
